[hdl/cdec_pkg.sv]
// Shared types, character codes and helper functions for the C string escape decoder.
// No dependencies.
package cdec_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned ValW       = 32;
  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  // ASCII codes the decoder looks at
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChLowU  = 8'h75;
  localparam logic [7:0] ChUpU   = 8'h55;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_OCT   = 3'd2,
    MODE_HEX   = 3'd3,
    MODE_UNI   = 3'd4
  } mode_e;

  // All result words caused by one input word
  typedef struct packed {
    logic [CntW-1:0]                  count;
    logic [MaxResults-1:0][ByteW-1:0] bytes;
    logic [MaxResults-1:0]            ends;
  } burst_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= ChZero && b <= ChNine) || (b >= ChLowA && b <= ChLowF) ||
           (b >= ChUpA && b <= ChUpF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] t;
    if (b >= ChZero && b <= ChNine) begin
      t = b - ChZero;
    end else if (b >= ChLowA && b <= ChLowF) begin
      t = b - ChLowA + 8'd10;
    end else begin
      t = b - ChUpA + 8'd10;
    end
    return t[3:0];
  endfunction

  // Named escapes; hit is low when the letter has no control code
  function automatic logic [8:0] named_code(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h61:   r = {1'b1, 8'd7};   // a
      8'h62:   r = {1'b1, 8'd8};   // b
      8'h74:   r = {1'b1, 8'd9};   // t
      8'h6E:   r = {1'b1, 8'd10};  // n
      8'h76:   r = {1'b1, 8'd11};  // v
      8'h66:   r = {1'b1, 8'd12};  // f
      8'h72:   r = {1'b1, 8'd13};  // r
      8'h65:   r = {1'b1, 8'd27};  // e
      default: r = {1'b0, b};
    endcase
    return r;
  endfunction

endpackage

[hdl/c_string_escape_decoder_core.sv]
// Top level of the C string escape decoder: input register, escape decoder,
// burst result register. Depends on cdec_pkg, cdec_decode, cdec_burst_buf.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  in      | in  | in_valid_i/in_ready_o | in_byte_i
//  out     | out | out_valid_o/out_ready_i | out_byte_o, literal_end_o, run_last_o
//
// One input word per cycle while each word gives at most one result word and
// the output is not stalled. A word giving several results holds the decoder
// until all drain; a backslash, the x or u after it, or a non-final escape
// digit gives none. Words pass the input register, then the burst register.
// Reset (async, active low) returns to plain text with an empty pipeline.
// Output stalls back up into the input register, then deassert in_ready_o.
module c_string_escape_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       literal_end_o,
  output logic       run_last_o
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             free;
  logic             fire;
  cdec_pkg::burst_t burst;

  // Decoder consumes the held word when the burst register can take its results
  assign fire       = in_valid_q && free;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  cdec_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_byte_q),
    .burst_o (burst)
  );

  // Words with no results never occupy the burst register
  cdec_burst_buf u_burst_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire && (burst.count != '0)),
    .burst_i       (burst),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .literal_end_o (literal_end_o),
    .run_last_o    (run_last_o)
  );

endmodule

[hdl/cdec_decode.sv]
// Escape decoder: holds the mode, octal count and escape value, and turns one
// registered input word into a burst of result words. Depends on cdec_pkg.
module cdec_decode (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  logic [7:0]              byte_i,
  output cdec_pkg::burst_t        burst_o
);

  cdec_pkg::mode_e       mode_q, mode_d;
  logic [1:0]            oct_cnt_q, oct_cnt_d;
  logic [cdec_pkg::ValW-1:0] val_q, val_d;

  always_comb begin
    logic                      do_plain;
    logic                      is_oct;
    logic [1:0]                cnt_n;
    logic [cdec_pkg::ValW-1:0] v;
    logic [cdec_pkg::CntW-1:0] n;
    logic [8:0]                nc;

    mode_d    = mode_q;
    oct_cnt_d = oct_cnt_q;
    val_d     = val_q;
    burst_o   = '0;
    n         = '0;
    do_plain  = 1'b0;
    is_oct    = (byte_i >= cdec_pkg::ChZero) && (byte_i <= cdec_pkg::ChSeven);
    cnt_n     = oct_cnt_q + 2'd1;
    v         = val_q;
    nc        = cdec_pkg::named_code(byte_i);

    case (mode_q)
      cdec_pkg::MODE_ESC: begin
        if (byte_i == cdec_pkg::ChLowU || byte_i == cdec_pkg::ChUpU) begin
          mode_d = cdec_pkg::MODE_UNI;
          val_d  = '0;
        end else if (byte_i == cdec_pkg::ChLowX) begin
          mode_d = cdec_pkg::MODE_HEX;
          val_d  = '0;
        end else if (is_oct) begin
          mode_d    = cdec_pkg::MODE_OCT;
          val_d     = {{(cdec_pkg::ValW-3){1'b0}}, byte_i[2:0]};
          oct_cnt_d = 2'd1;
        end else begin
          burst_o.bytes[n] = nc[7:0];
          n                = n + 1'b1;
          mode_d           = cdec_pkg::MODE_PLAIN;
        end
      end
      cdec_pkg::MODE_OCT: begin
        if (is_oct) begin
          v         = {val_q[cdec_pkg::ValW-4:0], byte_i[2:0]};
          val_d     = v;
          oct_cnt_d = cnt_n;
          if (cnt_n == 2'd3) begin
            burst_o.bytes[n] = v[7:0];
            n                = n + 1'b1;
            mode_d           = cdec_pkg::MODE_PLAIN;
            oct_cnt_d        = 2'd0;
            val_d            = '0;
          end
        end else begin
          burst_o.bytes[n] = val_q[7:0];
          n                = n + 1'b1;
          do_plain         = 1'b1;
        end
      end
      cdec_pkg::MODE_HEX: begin
        if (cdec_pkg::is_hex(byte_i)) begin
          val_d = {val_q[cdec_pkg::ValW-5:0], cdec_pkg::hex_val(byte_i)};
        end else begin
          burst_o.bytes[n] = val_q[7:0];
          n                = n + 1'b1;
          do_plain         = 1'b1;
        end
      end
      cdec_pkg::MODE_UNI: begin
        if (cdec_pkg::is_hex(byte_i)) begin
          val_d = {val_q[cdec_pkg::ValW-5:0], cdec_pkg::hex_val(byte_i)};
        end else begin
          // UTF-8; anything at or above 0x10000 uses the 4-byte form of bits 20:0
          if (val_q < 32'h80) begin
            burst_o.bytes[0] = val_q[7:0];
            n                = 3'd1;
          end else if (val_q < 32'h800) begin
            burst_o.bytes[0] = {3'b110, val_q[10:6]};
            burst_o.bytes[1] = {2'b10, val_q[5:0]};
            n                = 3'd2;
          end else if (val_q < 32'h10000) begin
            burst_o.bytes[0] = {4'b1110, val_q[15:12]};
            burst_o.bytes[1] = {2'b10, val_q[11:6]};
            burst_o.bytes[2] = {2'b10, val_q[5:0]};
            n                = 3'd3;
          end else begin
            burst_o.bytes[0] = {5'b11110, val_q[20:18]};
            burst_o.bytes[1] = {2'b10, val_q[17:12]};
            burst_o.bytes[2] = {2'b10, val_q[11:6]};
            burst_o.bytes[3] = {2'b10, val_q[5:0]};
            n                = 3'd4;
          end
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      mode_d    = cdec_pkg::MODE_PLAIN;
      oct_cnt_d = 2'd0;
      val_d     = '0;
      if (byte_i == cdec_pkg::ChQuote) begin
        burst_o.bytes[n] = 8'h00;
        burst_o.ends[n]  = 1'b1;
        n                = n + 1'b1;
      end else if (byte_i == cdec_pkg::ChBslash) begin
        mode_d = cdec_pkg::MODE_ESC;
      end else begin
        burst_o.bytes[n] = byte_i;
        n                = n + 1'b1;
      end
    end

    burst_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= cdec_pkg::MODE_PLAIN;
      oct_cnt_q <= 2'd0;
      val_q     <= '0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      oct_cnt_q <= oct_cnt_d;
      val_q     <= val_d;
    end
  end

endmodule

[hdl/cdec_burst_buf.sv]
// Result register: holds one burst and hands its words out one per cycle
// while the receiver is ready. Depends on cdec_pkg.
module cdec_burst_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cdec_pkg::burst_t burst_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             literal_end_o,
  output logic             run_last_o
);

  logic                      valid_q;
  cdec_pkg::burst_t          burst_q;
  logic [cdec_pkg::CntW-1:0] ptr_q;
  logic                      last;
  logic                      take;

  assign last          = (ptr_q == burst_q.count - 1'b1);
  assign take          = valid_q && out_ready_i;
  assign free_o        = !valid_q || (out_ready_i && last);
  assign out_valid_o   = valid_q;
  assign out_byte_o    = burst_q.bytes[ptr_q];
  assign literal_end_o = burst_q.ends[ptr_q];
  assign run_last_o    = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ptr_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      ptr_q   <= '0;
    end else if (take) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

endmodule

[hdl/cdec_checker.sv]
// Port-level checks for the C string escape decoder, bound to the top level.
// Depends on cdec_pkg and c_string_escape_decoder_core.
module cdec_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       literal_end_o,
  input logic       run_last_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(run_last_o))
    else $error("output word changed while stalled");

  // terminating NUL is always the last word of its run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && literal_end_o |-> run_last_o)
    else $error("literal end not last in run");

  a_end_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && literal_end_o |-> out_byte_o == 8'h00)
    else $error("literal end byte not NUL");

  // a quote gives a result in every mode, so one accepted into an empty
  // pipeline shows up after the input register, then the burst register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && in_byte_i == cdec_pkg::ChQuote &&
    $past(in_ready_o) && $past(!in_valid_i) && $past(!out_valid_o) |=> ##1 out_valid_o)
    else $error("result missing after idle accept");

endmodule

bind c_string_escape_decoder_core cdec_checker u_cdec_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench for c_string_escape_decoder_core: raw literal bytes in,
// cooked bytes checked against an in-bench decoder model. Depends on cdec_pkg.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RandomItems = 480;
  localparam int unsigned HoldOff     = 400;     // long receiver stall, in cycles
  localparam int unsigned HoldAt      = 120;     // words received before that stall
  localparam int unsigned DrainCycles = 16;      // settle time after the model owes nothing more, in cycles
  localparam int unsigned CycleLimit  = 400000;

  // One cooked output word as the block should present it
  typedef struct packed {
    logic [7:0] data;
    logic       lend;
    logic       last;
  } cooked_t;

  // Decoder model plus the queue of cooked words still owed by the block
  class cooked_board;
    cooked_t          owed_q[$];
    cdec_pkg::mode_e  mode;
    logic [1:0]       oct_n;
    logic [31:0]      acc;
    int unsigned errors, checked, literals, n_oct, n_hex;
    int unsigned utf_w[5];

    function new();
      mode   = cdec_pkg::MODE_PLAIN;
      oct_n  = 2'd0;
      acc    = 32'd0;
      errors = 0;
      checked = 0;
      literals = 0;
      n_oct  = 0;
      n_hex  = 0;
      foreach (utf_w[i]) utf_w[i] = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void owe(logic [7:0] v, logic lend);
      cooked_t c;
      c.data = v;
      c.lend = lend;
      c.last = 1'b0;
      owed_q.insert(owed_q.size(), c);
    endfunction

    function logic is_hex_digit(logic [7:0] b);
      return (b >= cdec_pkg::ChZero && b <= cdec_pkg::ChNine) ||
             (b >= cdec_pkg::ChLowA && b <= cdec_pkg::ChLowF) ||
             (b >= cdec_pkg::ChUpA && b <= cdec_pkg::ChUpF);
    endfunction

    // Low nibble of '0'..'9' is the digit; a letter's low nibble is its value less nine
    function logic [3:0] nibble(logic [7:0] b);
      if (b <= cdec_pkg::ChNine) return b[3:0];
      return b[3:0] + 4'd9;
    endfunction

    function logic [7:0] escaped_char(logic [7:0] b);
      case (b)
        "a":     return 8'd7;
        "b":     return 8'd8;
        "t":     return 8'd9;
        "n":     return 8'd10;
        "v":     return 8'd11;
        "f":     return 8'd12;
        "r":     return 8'd13;
        "e":     return 8'd27;
        default: return b;
      endcase
    endfunction

    // Anything at or above 0x10000 takes the 4-byte form of bits 20:0
    function void owe_utf8(logic [31:0] v);
      if (v < 32'h80) begin
        owe(v[7:0], 1'b0);
        utf_w[1]++;
      end else if (v < 32'h800) begin
        owe({3'b110, v[10:6]}, 1'b0);
        owe({2'b10, v[5:0]}, 1'b0);
        utf_w[2]++;
      end else if (v < 32'h10000) begin
        owe({4'b1110, v[15:12]}, 1'b0);
        owe({2'b10, v[11:6]}, 1'b0);
        owe({2'b10, v[5:0]}, 1'b0);
        utf_w[3]++;
      end else begin
        owe({5'b11110, v[20:18]}, 1'b0);
        owe({2'b10, v[17:12]}, 1'b0);
        owe({2'b10, v[11:6]}, 1'b0);
        owe({2'b10, v[5:0]}, 1'b0);
        utf_w[4]++;
      end
    endfunction

    // Accepted raw word: advance the model, queue whatever it produces
    function void note_raw(logic [7:0] b);
      int unsigned base;
      logic        as_plain;
      base     = owed_q.size();
      as_plain = 1'b0;
      case (mode)
        cdec_pkg::MODE_ESC: begin
          if (b == cdec_pkg::ChLowU || b == cdec_pkg::ChUpU) begin
            mode = cdec_pkg::MODE_UNI;
            acc  = 32'd0;
          end else if (b == cdec_pkg::ChLowX) begin
            mode = cdec_pkg::MODE_HEX;
            acc  = 32'd0;
          end else if (b >= cdec_pkg::ChZero && b <= cdec_pkg::ChSeven) begin
            mode  = cdec_pkg::MODE_OCT;
            acc   = {29'd0, b[2:0]};
            oct_n = 2'd1;
          end else begin
            owe(escaped_char(b), 1'b0);
            mode = cdec_pkg::MODE_PLAIN;
          end
        end
        cdec_pkg::MODE_OCT: begin
          if (b >= cdec_pkg::ChZero && b <= cdec_pkg::ChSeven) begin
            acc   = {acc[28:0], b[2:0]};
            oct_n = oct_n + 2'd1;
            if (oct_n == 2'd3) begin
              owe(acc[7:0], 1'b0);
              n_oct++;
              mode  = cdec_pkg::MODE_PLAIN;
              oct_n = 2'd0;
              acc   = 32'd0;
            end
          end else begin
            owe(acc[7:0], 1'b0);
            n_oct++;
            as_plain = 1'b1;
          end
        end
        cdec_pkg::MODE_HEX: begin
          if (is_hex_digit(b)) begin
            acc = {acc[27:0], nibble(b)};
          end else begin
            owe(acc[7:0], 1'b0);
            n_hex++;
            as_plain = 1'b1;
          end
        end
        cdec_pkg::MODE_UNI: begin
          if (is_hex_digit(b)) begin
            acc = {acc[27:0], nibble(b)};
          end else begin
            owe_utf8(acc);
            as_plain = 1'b1;
          end
        end
        default: as_plain = 1'b1;
      endcase

      // plain bytes and the byte that closed a numeric escape are handled here
      if (as_plain) begin
        mode  = cdec_pkg::MODE_PLAIN;
        oct_n = 2'd0;
        acc   = 32'd0;
        if (b == cdec_pkg::ChQuote) begin
          owe(8'h00, 1'b1);
          literals++;
        end else if (b == cdec_pkg::ChBslash) begin
          mode = cdec_pkg::MODE_ESC;
        end else begin
          owe(b, 1'b0);
        end
      end
      if (owed_q.size() > base) owed_q[owed_q.size()-1].last = 1'b1;
    endfunction

    function void check_cooked(logic [7:0] data, logic lend, logic last);
      cooked_t w;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected word data=%h end=%b last=%b", $time, data, lend, last);
        errors++;
        return;
      end
      w = owed_q.pop_front();
      checked++;
      if (data !== w.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, w.data, data);
        errors++;
      end
      if (lend !== w.lend) begin
        $display("%0t: literal_end expected %b actual %b", $time, w.lend, lend);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: run_last expected %b actual %b", $time, w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       literal_end_o;
  logic       run_last_o;

  cooked_board board;
  logic [7:0]  raw_q[$];     // whole raw byte stream, built before reset is released
  int unsigned cycles;

  c_string_escape_decoder_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .literal_end_o(literal_end_o),
    .run_last_o   (run_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: nothing else bounds a hung handshake
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("c_string_escape_decoder_core regression: fail");
    $finish;
  end

  function automatic void add_raw(logic [7:0] b);
    raw_q.insert(raw_q.size(), b);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) add_raw(s[i]);
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // One random piece of a literal body. Mostly well-formed escapes with
  // random digits; plain bytes and stray bytes cover every bit of the word.
  function automatic void add_fragment();
    int unsigned k, n;
    string       letters;
    letters = "abtnvfre";
    k = $urandom_range(0, 99);
    if (k < 30) begin
      add_raw(8'($urandom_range(0, 255)));
    end else if (k < 40) begin
      add_raw(cdec_pkg::ChBslash);
      add_raw(letters[$urandom_range(0, 7)]);
    end else if (k < 47) begin
      add_raw(cdec_pkg::ChBslash);
      add_raw(8'($urandom_range(0, 255)));
    end else if (k < 60) begin
      add_raw(cdec_pkg::ChBslash);
      n = $urandom_range(1, 3);
      repeat (n) add_raw(cdec_pkg::ChZero + 8'($urandom_range(0, 7)));
    end else if (k < 72) begin
      add_raw(cdec_pkg::ChBslash);
      add_raw(cdec_pkg::ChLowX);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 10) : $urandom_range(0, 2);
      repeat (n) add_raw(rand_hex_digit());
    end else if (k < 88) begin
      // digit count spreads the code point over all four UTF-8 widths
      add_raw(cdec_pkg::ChBslash);
      add_raw($urandom_range(0, 1) ? cdec_pkg::ChLowU : cdec_pkg::ChUpU);
      n = $urandom_range(0, 9);
      repeat (n) add_raw(rand_hex_digit());
    end else if (k < 95) begin
      add_raw(cdec_pkg::ChQuote);
    end else begin
      add_raw(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_stream();
    // extremes of the byte as plain text
    add_raw(8'h00);
    add_raw(8'hFF);
    // escaped quote stays in the literal
    push_str("\\\"");
    // octal closed by its third digit, value wraps to 8 bits
    push_str("\\777");
    // one-digit octal closed by the quote that ends the literal
    push_str("\\7\"");
    // hex with no digits, then end of literal
    push_str("\\x\"");
    // unicode with no digits, closed by a new escape
    push_str("\\u\\q");
    // code point that wraps past 32 bits and keeps only bits 20:0
    push_str("\\UFFFFFFFFF!");
    while (raw_q.size() < RandomItems) add_fragment();
    add_raw(cdec_pkg::ChQuote);
  endfunction

  // Idle draw shared by both sides; calm runs give stretches without gaps
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Sender: valid stays up with a steady word until the block takes it
  task automatic send_raw();
    int unsigned gap, calm;
    calm = 0;
    foreach (raw_q[i]) begin
      gap = draw_gap(calm);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_byte_i  <= raw_q[i];
      do @(posedge clk_i); while (!in_ready_o);
      board.note_raw(raw_q[i]);
    end
    in_valid_i <= 1'b0;
  endtask

  // Receiver: random ready gaps, one long hold-off to back the block up
  task automatic take_cooked();
    int unsigned gap, calm, seen;
    logic        held;
    calm = 0;
    seen = 0;
    held = 1'b0;
    forever begin
      gap = draw_gap(calm);
      if (!held && seen == HoldAt) begin
        gap  = HoldOff;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_cooked(out_byte_o, literal_end_o, run_last_o);
      seen++;
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_byte_i   <= 8'h00;
    out_ready_i <= 1'b0;
    board = new();
    build_stream();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      take_cooked();
    join_none
    send_raw();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d raw words, %0d cooked words checked, %0d literals closed",
             raw_q.size(), board.checked, board.literals);
    $display("octal %0d, hex %0d, utf-8 widths 1/2/3/4: %0d/%0d/%0d/%0d",
             board.n_oct, board.n_hex, board.utf_w[1], board.utf_w[2],
             board.utf_w[3], board.utf_w[4]);
    if (board.errors == 0) begin
      $display("c_string_escape_decoder_core regression: pass");
    end else begin
      $display("c_string_escape_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
